/* rtl/cset_pkg.sv */
// Shared constants and types for the cache set replacement block.
// No dependencies; compile before every other file.
package cset_pkg;

   // Fixed widths of the channel fields.
   localparam int TAG_W = 20;
   localparam int WAY_W = 2;

   // Defaults for the top-level parameters.
   localparam int WAYS_DEF     = 4;
   localparam int TAG_BITS_DEF = 20;
   localparam int AGE_BITS_DEF = 8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request tag
      logic lookup;    // resolve hit / fill way / victim
      logic commit;    // write the set state and load the response
   } cset_cmd_type;

endpackage

/* rtl/cset_if.sv */
// Channel interfaces: request, response and configuration write.
// Depends on cset_pkg for the field widths.
interface cset_req_if;
   logic                        valid;
   logic                        ready;
   logic [cset_pkg::TAG_W-1:0]  access_tag;
   modport source (output valid, output access_tag, input ready);
   modport sink   (input valid, input access_tag, output ready);
endinterface

interface cset_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [cset_pkg::WAY_W-1:0]  way_used;
   logic                        evicted_valid;
   logic [cset_pkg::TAG_W-1:0]  evicted_tag;
   logic                        set_full;
   modport source (output valid, output hit, output way_used, output evicted_valid,
                   output evicted_tag, output set_full, input ready);
   modport sink   (input valid, input hit, input way_used, input evicted_valid,
                   input evicted_tag, input set_full, output ready);
endinterface

interface cset_csr_if;
   logic valid;
   logic ready;
   logic policy_mode;
   modport source (output valid, output policy_mode, input ready);
   modport sink   (input valid, input policy_mode, output ready);
endinterface

/* rtl/cset_ctrl.sv */
// Controller for the cache set: sequences capture, lookup and commit.
// Depends on cset_pkg for the command struct.
module cset_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cset_pkg::cset_cmd_type cmd
);

   typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_UPDATE} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output slot can be loaded when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_UPDATE) && out_free);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture  = req_valid && req_ready;
      cmd.lookup   = (state_ff == S_LOOKUP);
      cmd.commit   = (state_ff == S_UPDATE) && out_free;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = cmd.capture ? S_LOOKUP : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/cset_dp.sv */
// Datapath for the cache set: tags, valid bits, ages, policy register and
// the response payload register. Depends on cset_pkg.
module cset_dp #(
   parameter int WAYS     = cset_pkg::WAYS_DEF,
   parameter int TAG_BITS = cset_pkg::TAG_BITS_DEF,
   parameter int AGE_BITS = cset_pkg::AGE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cset_pkg::cset_cmd_type      cmd,
   input  logic [cset_pkg::TAG_W-1:0]  access_tag,
   input  logic                        csr_valid,
   input  logic                        csr_policy_mode,
   output logic                        hit,
   output logic [cset_pkg::WAY_W-1:0]  way_used,
   output logic                        evicted_valid,
   output logic [cset_pkg::TAG_W-1:0]  evicted_tag,
   output logic                        set_full
);

   localparam int TW   = cset_pkg::TAG_W;
   localparam int UW0  = cset_pkg::WAY_W;
   localparam int WIDX = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int PAD  = 1 << WIDX;
   localparam int NODES = 2 * PAD - 1;
   localparam int WIDE = (TAG_BITS > TW) ? TAG_BITS : TW;
   localparam int UW   = (WIDX > UW0) ? WIDX : UW0;
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   // Set state
   logic [TAG_BITS-1:0] tags_ff   [WAYS];
   logic [WAYS-1:0]     valid_ff, valid_in;
   logic [AGE_BITS-1:0] ages_ff   [WAYS];
   logic [AGE_BITS-1:0] ages_in   [WAYS];
   logic                policy_ff;

   // Request and lookup decision
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                hit_ff, hit_in;
   logic [WIDX-1:0]     way_ff, way_in;
   logic                evict_ff, evict_in;
   logic [TAG_BITS-1:0] evtag_ff, evtag_in;

   // Response payload
   logic                rsp_hit_ff;
   logic [UW0-1:0]      rsp_way_ff;
   logic                rsp_evict_ff;
   logic [TW-1:0]       rsp_evtag_ff;
   logic                rsp_full_ff;

   logic [WIDE-1:0]     tag_wide;
   logic [WIDE-1:0]     evtag_wide;
   logic [UW-1:0]       way_wide;
   logic                any_empty;
   logic [WIDX-1:0]     hit_way, empty_way;
   logic [AGE_BITS-1:0] t_age [NODES];
   logic [WIDX-1:0]     t_idx [NODES];
   logic [AGE_BITS-1:0] old_age;

   assign tag_wide   = WIDE'(access_tag);
   assign tag_in     = tag_wide[TAG_BITS-1:0];
   assign evtag_wide = WIDE'(evtag_ff);
   assign way_wide   = UW'(way_ff);

   // Lookup: lowest valid match, lowest empty way, oldest way by a
   // tie-to-left max tree.
   always_comb begin
      hit_in    = 1'b0;
      hit_way   = '0;
      any_empty = 1'b0;
      empty_way = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tags_ff[i] == tag_ff)) begin
            hit_in  = 1'b1;
            hit_way = WIDX'(i);
         end
         if (!valid_ff[i]) begin
            any_empty = 1'b1;
            empty_way = WIDX'(i);
         end
      end
      for (int i = 0; i < PAD; i++) begin
         t_age[PAD-1+i] = (i < WAYS) ? ages_ff[i] : '0;
         t_idx[PAD-1+i] = WIDX'(i);
      end
      for (int n = PAD - 2; n >= 0; n--) begin
         if (t_age[2*n+2] > t_age[2*n+1]) begin
            t_age[n] = t_age[2*n+2];
            t_idx[n] = t_idx[2*n+2];
         end else begin
            t_age[n] = t_age[2*n+1];
            t_idx[n] = t_idx[2*n+1];
         end
      end
      evict_in = 1'b0;
      evtag_in = '0;
      if (hit_in) begin
         way_in = hit_way;
      end else if (any_empty) begin
         way_in = empty_way;
      end else begin
         way_in   = t_idx[0];
         evict_in = 1'b1;
         evtag_in = tags_ff[t_idx[0]];
      end
   end

   // Commit: install tag, mark valid, apply the age update of the policy.
   always_comb begin
      old_age  = ages_ff[way_ff];
      valid_in = valid_ff;
      valid_in[way_ff] = 1'b1;
      for (int i = 0; i < WAYS; i++) begin
         ages_in[i] = ages_ff[i];
      end
      if (!policy_ff) begin
         if (old_age != '0) begin
            for (int i = 0; i < WAYS; i++) begin
               if (valid_ff[i] && (ages_ff[i] <= old_age) && (ages_ff[i] != AGE_MAX)) begin
                  ages_in[i] = ages_ff[i] + 1'b1;
               end
            end
            ages_in[way_ff] = '0;
         end
      end else if (!hit_ff) begin
         for (int i = 0; i < WAYS; i++) begin
            if (ages_ff[i] != AGE_MAX) ages_in[i] = ages_ff[i] + 1'b1;
         end
         ages_in[way_ff] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         policy_ff <= 1'b0;
         for (int i = 0; i < WAYS; i++) ages_ff[i] <= '0;
      end else begin
         if (csr_valid) policy_ff <= csr_policy_mode;
         if (cmd.commit) begin
            valid_ff <= valid_in;
            for (int i = 0; i < WAYS; i++) ages_ff[i] <= ages_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) tag_ff <= tag_in;
      if (cmd.lookup) begin
         hit_ff   <= hit_in;
         way_ff   <= way_in;
         evict_ff <= evict_in;
         evtag_ff <= evtag_in;
      end
      if (cmd.commit) begin
         if (!hit_ff) tags_ff[way_ff] <= tag_ff;
         rsp_hit_ff   <= hit_ff;
         rsp_way_ff   <= way_wide[UW0-1:0];
         rsp_evict_ff <= evict_ff;
         rsp_evtag_ff <= evtag_wide[TW-1:0];
         rsp_full_ff  <= &valid_in;
      end
   end

   assign hit           = rsp_hit_ff;
   assign way_used      = rsp_way_ff;
   assign evicted_valid = rsp_evict_ff;
   assign evicted_tag   = rsp_evtag_ff;
   assign set_full      = rsp_full_ff;

endmodule

/* rtl/cache_set_replacement_top.sv */
// Top level of the cache set replacement block.
// Depends on cset_pkg, the channel interfaces, cset_ctrl and cset_dp.
//
//   channel | dir | fields                                              | moves
//   --------+-----+-----------------------------------------------------+-------------
//   req     | in  | access_tag[19:0]                                    | one request
//   rsp     | out | hit, way_used[1:0], evicted_valid, evicted_tag[19:0], set_full | one result
//   csr     | in  | policy_mode (0 LRU, 1 FIFO)                         | register write
//
// Each request passes a lookup step, which compares tags and picks the fill or
// victim way (a max tree over the way ages), and then a commit step, which
// writes the set state and loads the response register. A new request can be
// accepted during the commit step, so back-to-back requests need no idle step.
// Reset (synchronous, active high) clears valid bits, ages and the policy;
// tags are left unwritten. A stalled response holds the commit stage, and
// with it the next request; the csr port is always ready.
module cache_set_replacement_top #(
   parameter int WAYS     = cset_pkg::WAYS_DEF,
   parameter int TAG_BITS = cset_pkg::TAG_BITS_DEF,
   parameter int AGE_BITS = cset_pkg::AGE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cset_req_if.sink   req,
   cset_rsp_if.source rsp,
   cset_csr_if.sink   csr
);

   cset_pkg::cset_cmd_type cmd;

   // Configuration writes land in a single flop; never stall them.
   assign csr.ready = 1'b1;

   // Sequence the request through lookup and commit.
   cset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // Hold the set state and the response payload.
   cset_dp #(
      .WAYS     (WAYS),
      .TAG_BITS (TAG_BITS),
      .AGE_BITS (AGE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .access_tag      (req.access_tag),
      .csr_valid       (csr.valid),
      .csr_policy_mode (csr.policy_mode),
      .hit             (rsp.hit),
      .way_used        (rsp.way_used),
      .evicted_valid   (rsp.evicted_valid),
      .evicted_tag     (rsp.evicted_tag),
      .set_full        (rsp.set_full)
   );

endmodule
